/* rtl/core/gpr_instruction_executor_assert.svh */
// Assertion macros shared by the executor RTL; empty when synthesizing.
`ifndef GPR_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define GPR_INSTRUCTION_EXECUTOR_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check that is switched off while reset is asserted.
`define GPR_ASSERT(NAME, CLK, RSTN, PROP) \
    NAME: assert property (@(posedge CLK) disable iff (!RSTN) PROP) \
        else $error("gpr executor check failed");

// Clocked check that also holds while reset is asserted.
`define GPR_ASSERT_ALWAYS(NAME, CLK, PROP) \
    NAME: assert property (@(posedge CLK) PROP) \
        else $error("gpr executor check failed");

`else

`define GPR_ASSERT(NAME, CLK, RSTN, PROP)
`define GPR_ASSERT_ALWAYS(NAME, CLK, PROP)

`endif

`endif

/* rtl/core/gie_pkg.sv */
// Shared opcodes, constants, helper functions and types of the instruction executor.
package gie_pkg;

    // Opcodes in instruction bits 31:24.
    localparam logic [7:0] OP_ADDI    = 8'd1;
    localparam logic [7:0] OP_B       = 8'd2;
    localparam logic [7:0] OP_BEQZ    = 8'd3;
    localparam logic [7:0] OP_BGE     = 8'd4;
    localparam logic [7:0] OP_BNE     = 8'd5;
    localparam logic [7:0] OP_LA      = 8'd6;
    localparam logic [7:0] OP_LB      = 8'd7;
    localparam logic [7:0] OP_LI      = 8'd8;
    localparam logic [7:0] OP_SUBI    = 8'd9;
    localparam logic [7:0] OP_SYSCALL = 8'd10;

    // Item kinds.
    localparam logic FUNC_EXEC  = 1'b0;
    localparam logic FUNC_STORE = 1'b1;

    // Reported services.
    localparam logic [1:0] SVC_NONE  = 2'd0;
    localparam logic [1:0] SVC_PRINT = 2'd1;
    localparam logic [1:0] SVC_READ  = 2'd2;
    localparam logic [1:0] SVC_END   = 2'd3;

    // Service request codes found in the service register.
    localparam logic [31:0] SYS_PRINT_STR = 32'd4;
    localparam logic [31:0] SYS_READ_STR  = 32'd8;
    localparam logic [31:0] SYS_EXIT      = 32'd10;

    // Registers a system call reads.
    localparam logic [7:0] REG_SVC = 8'd3;
    localparam logic [7:0] REG_ARG = 8'd1;

    // Program counter after reset and the word read outside all segments.
    localparam logic [31:0] RESET_PC     = 32'h0000_1000;
    localparam logic [31:0] OUTSIDE_WORD = 32'h0000_3000;

    typedef logic [3:0] cost_t;

    // Result of the execute stage for one item.
    typedef struct packed {
        logic [31:0] next_pc;
        logic        halt_next;
        logic [1:0]  service;
        logic [31:0] arg;
        logic        wr_en;
        logic [31:0] wr_val;
        logic        is_lb;
        logic [31:0] lb_addr;
        logic        cnt_en;
        cost_t       cost;
    } exec_t;

    // Sign-magnitude immediate: bit 7 sign, bits 5:0 magnitude, bit 6 ignored.
    function automatic logic [31:0] sm_imm(input logic [7:0] field);
        logic [31:0] mag;
        mag = {26'd0, field[5:0]};
        return field[7] ? (32'd0 - mag) : mag;
    endfunction

    // Cycle cost of an opcode; zero marks an unknown opcode.
    function automatic cost_t op_cost(input logic [7:0] op);
        cost_t c;
        unique case (op)
            OP_ADDI:    c = 4'd6;
            OP_B:       c = 4'd4;
            OP_BEQZ:    c = 4'd5;
            OP_BGE:     c = 4'd5;
            OP_BNE:     c = 4'd5;
            OP_LA:      c = 4'd5;
            OP_LB:      c = 4'd6;
            OP_LI:      c = 4'd3;
            OP_SUBI:    c = 4'd6;
            OP_SYSCALL: c = 4'd8;
            default:    c = 4'd0;
        endcase
        return c;
    endfunction

    // First read operand: the left field, or the service register for a system call.
    function automatic logic [7:0] rd_sel_a(input logic [31:0] ins);
        return (ins[31:24] == OP_SYSCALL) ? REG_SVC : ins[23:16];
    endfunction

    // Second read operand: the center field, or the argument register for a system call.
    function automatic logic [7:0] rd_sel_b(input logic [31:0] ins);
        return (ins[31:24] == OP_SYSCALL) ? REG_ARG : ins[15:8];
    endfunction

endpackage

/* rtl/core/gie_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module gie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and read-first registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/gie_exec.sv */
// Execute unit: decodes one instruction and computes pc, write-back, service and cost.
module gie_exec (
    input  logic          func,
    input  logic [31:0]   ins,
    input  logic [31:0]   pc,
    input  logic          halted,
    input  logic [31:0]   opa,
    input  logic [31:0]   opb,
    output gie_pkg::exec_t res
);

    import gie_pkg::*;

    logic [7:0]  op;
    logic [31:0] imm;
    logic [31:0] pc_inc;
    logic [31:0] pc_br;
    cost_t       cost;

    assign op     = ins[31:24];
    assign imm    = sm_imm(ins[7:0]);
    assign pc_inc = pc + 32'd1;
    assign pc_br  = pc_inc + imm;
    assign cost   = op_cost(op);

    // Decode and execute; store items and a halted core leave the state alone.
    always_comb
    begin
        res.next_pc   = pc;
        res.halt_next = halted;
        res.service   = SVC_NONE;
        res.arg       = 32'd0;
        res.wr_en     = 1'b0;
        res.wr_val    = 32'd0;
        res.is_lb     = 1'b0;
        res.lb_addr   = opb + imm;
        res.cnt_en    = 1'b0;
        res.cost      = cost;

        if (func == FUNC_EXEC && !halted)
        begin
            res.next_pc = pc_inc;
            res.cnt_en  = (cost != 4'd0);
            unique case (op)
                OP_ADDI:
                begin
                    res.wr_en  = 1'b1;
                    res.wr_val = opb + imm;
                end
                OP_B:
                begin
                    res.next_pc = pc_br;
                end
                OP_BEQZ:
                begin
                    if (opa == 32'd0)
                    begin
                        res.next_pc = pc_br;
                    end
                end
                OP_BGE:
                begin
                    if (opa >= opb)
                    begin
                        res.next_pc = pc_br;
                    end
                end
                OP_BNE:
                begin
                    if (opa != opb)
                    begin
                        res.next_pc = pc_br;
                    end
                end
                OP_LA:
                begin
                    res.wr_en  = 1'b1;
                    res.wr_val = {16'd0, ins[15:0]};
                end
                OP_LB:
                begin
                    // The byte itself arrives from data memory one stage later.
                    res.wr_en = 1'b1;
                    res.is_lb = 1'b1;
                end
                OP_LI:
                begin
                    res.wr_en  = 1'b1;
                    res.wr_val = {24'd0, ins[15:8]};
                end
                OP_SUBI:
                begin
                    res.wr_en  = 1'b1;
                    res.wr_val = opb - imm;
                end
                OP_SYSCALL:
                begin
                    // Operand a holds the service register, operand b the argument register.
                    res.arg = opb;
                    if (opa == SYS_PRINT_STR)
                    begin
                        res.service = SVC_PRINT;
                    end
                    else if (opa == SYS_READ_STR)
                    begin
                        res.service = SVC_READ;
                    end
                    else if (opa == SYS_EXIT)
                    begin
                        res.service   = SVC_END;
                        res.halt_next = 1'b1;
                    end
                    else
                    begin
                        res.halt_next = 1'b1;
                    end
                end
                default:
                begin
                    // Unknown opcode halts; the counters stay as they are.
                    res.halt_next = 1'b1;
                end
            endcase
        end
    end

endmodule

/* rtl/core/gpr_instruction_executor.sv */
// Top level of the register-file instruction executor with its memories and pipeline.
//
//  Channel | Dir | Handshake                  | Payload
//  input   | in  | in_valid / in_stall        | func, instruction_word, store_address, store_word
//  output  | out | out_valid / out_stall      | next_pc, halted, service, service_arg,
//          |     |                            | instr_count, cycle_count
//  config  | in  | cfg_wr_en                  | cfg_wr_data (start_pc)
//
// One item per cycle is sustained while the output is not stalled; an item passes from
// acceptance to its result in the output register through stage 1 and stage 2: the register
// file is read at acceptance, then execute with the data memory read, then byte select and
// register write-back, each stage bounded by a registered RAM read.
// After reset a clearing pass zeroes both memories, one entry per cycle, stepping through
// max(3*SEG_WORDS, REG_COUNT) entries (192 by default); no item is accepted meanwhile.
// A stalled output fills the pipeline stages behind it before the input stalls.
// Results written back are forwarded to younger items, so there is no interlock.
`include "gpr_instruction_executor_assert.svh"

module gpr_instruction_executor #(
    parameter int SEG_WORDS = 64,
    parameter int REG_COUNT = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [31:0] instruction_word,
    input  logic [15:0] store_address,
    input  logic [31:0] store_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] next_pc,
    output logic        halted,
    output logic [1:0]  service,
    output logic [31:0] service_arg,
    output logic [31:0] instr_count,
    output logic [31:0] cycle_count
);

    import gie_pkg::*;

    localparam int MEM_DEPTH = 3 * SEG_WORDS;
    localparam int MA_W      = $clog2(MEM_DEPTH);
    localparam int RIDX_W    = $clog2(REG_COUNT);
    localparam int CLR_LEN   = (MEM_DEPTH > REG_COUNT) ? MEM_DEPTH : REG_COUNT;
    localparam int CLR_W     = $clog2(CLR_LEN);

    // Base word of a segment in data memory.
    function automatic logic [MA_W-1:0] seg_base(input logic [1:0] seg);
        logic [MA_W-1:0] b;
        unique case (seg)
            2'd2:    b = MA_W'(SEG_WORDS);
            2'd3:    b = MA_W'(2 * SEG_WORDS);
            default: b = '0;
        endcase
        return b;
    endfunction

    // Architectural state.
    logic [31:0]       pc_reg;
    logic              halt_reg;
    logic [31:0]       instr_cnt_reg;
    logic [31:0]       cyc_cnt_reg;

    // Clearing pass.
    logic              clr_busy_reg;
    logic [CLR_W-1:0]  clr_cnt_reg;

    // Stage 1: operands arrive from the register file.
    logic              s1_v_reg;
    logic              s1_func_reg;
    logic [31:0]       s1_ins_reg;
    logic [15:0]       s1_saddr_reg;
    logic [31:0]       s1_sword_reg;
    logic              snap_v_reg;
    logic [RIDX_W-1:0] snap_idx_reg;
    logic [31:0]       snap_data_reg;

    // Stage 2: load data arrives from data memory, write-back.
    logic              s2_v_reg;
    logic [31:0]       s2_pc_reg;
    logic              s2_halt_reg;
    logic [1:0]        s2_svc_reg;
    logic [31:0]       s2_arg_reg;
    logic [31:0]       s2_icnt_reg;
    logic [31:0]       s2_ccnt_reg;
    logic              s2_wr_ok_reg;
    logic [RIDX_W-1:0] s2_widx_reg;
    logic [31:0]       s2_wval_reg;
    logic              s2_is_lb_reg;
    logic              s2_seg_ok_reg;
    logic              s2_idx_ok_reg;
    logic [1:0]        s2_lane_reg;

    // Output register.
    logic              out_v_reg;
    logic [31:0]       out_pc_reg;
    logic              out_halt_reg;
    logic [1:0]        out_svc_reg;
    logic [31:0]       out_arg_reg;
    logic [31:0]       out_icnt_reg;
    logic [31:0]       out_ccnt_reg;

    // Handshake and stage enables.
    logic              out_en;
    logic              s2_en;
    logic              s1_en;
    logic              in_acc;
    logic              s1_move;

    // Register file ports.
    logic              rf_we;
    logic [RIDX_W-1:0] rf_waddr;
    logic [31:0]       rf_wdata;
    logic [7:0]        rd_a8;
    logic [7:0]        rd_b8;
    logic [RIDX_W-1:0] rf_raddr_a;
    logic [RIDX_W-1:0] rf_raddr_b;
    logic [31:0]       rfa_q;
    logic [31:0]       rfb_q;
    logic              pipe_wr;

    // Data memory ports.
    logic              dm_we;
    logic [MA_W-1:0]   dm_waddr;
    logic [31:0]       dm_wdata;
    logic [MA_W-1:0]   dm_raddr;
    logic [31:0]       dm_q;

    // Stage 1 logic.
    logic [7:0]        a_idx8;
    logic [7:0]        b_idx8;
    logic              a_ok;
    logic              b_ok;
    logic [RIDX_W-1:0] a_idx;
    logic [RIDX_W-1:0] b_idx;
    logic [31:0]       opa;
    logic [31:0]       opb;
    exec_t             ex;
    logic [7:0]        dest8;
    logic              wr_ok;
    logic [3:0]        ld_seg;
    logic [9:0]        ld_widx;
    logic              ld_seg_ok;
    logic              ld_idx_ok;
    logic [3:0]        st_seg;
    logic [11:0]       st_widx;
    logic              st_ok;
    logic [31:0]       icnt_next;
    logic [31:0]       ccnt_next;

    // Stage 2 logic.
    logic [31:0]       ld_word;
    logic [7:0]        ld_byte;
    logic [31:0]       s2_wdata;

    // Stage enables: a stage loads when it is empty or its item moves on.
    assign out_en   = !out_v_reg || !out_stall;
    assign s2_en    = !s2_v_reg || out_en;
    assign s1_en    = !s1_v_reg || s2_en;
    assign in_stall = clr_busy_reg || !s1_en;
    assign in_acc   = in_valid && !in_stall;
    assign s1_move  = s1_v_reg && s2_en;

    // Clearing pass over both memories after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_cnt_reg == CLR_W'(CLR_LEN - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Register file: two copies give two read ports.
    assign pipe_wr    = s2_v_reg && s2_wr_ok_reg && out_en;
    assign rf_we      = clr_busy_reg
                        ? ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(REG_COUNT))
                        : pipe_wr;
    assign rf_waddr   = clr_busy_reg ? clr_cnt_reg[RIDX_W-1:0] : s2_widx_reg;
    assign rf_wdata   = clr_busy_reg ? 32'd0 : s2_wdata;
    assign rd_a8      = rd_sel_a(instruction_word);
    assign rd_b8      = rd_sel_b(instruction_word);
    assign rf_raddr_a = rd_a8[RIDX_W-1:0];
    assign rf_raddr_b = rd_b8[RIDX_W-1:0];

    gie_ram #(
        .WIDTH (32),
        .DEPTH (REG_COUNT)
    ) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (s1_en),
        .raddr (rf_raddr_a),
        .rdata (rfa_q)
    );

    gie_ram #(
        .WIDTH (32),
        .DEPTH (REG_COUNT)
    ) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (s1_en),
        .raddr (rf_raddr_b),
        .rdata (rfb_q)
    );

    // Operand select with forwarding from stage 2 and from the write seen at entry.
    assign a_idx8 = rd_sel_a(s1_ins_reg);
    assign b_idx8 = rd_sel_b(s1_ins_reg);
    assign a_ok   = ({1'b0, a_idx8} < 9'(REG_COUNT));
    assign b_ok   = ({1'b0, b_idx8} < 9'(REG_COUNT));
    assign a_idx  = a_idx8[RIDX_W-1:0];
    assign b_idx  = b_idx8[RIDX_W-1:0];

    always_comb
    begin
        if (!a_ok)
        begin
            opa = 32'd0;
        end
        else if (s2_v_reg && s2_wr_ok_reg && s2_widx_reg == a_idx)
        begin
            opa = s2_wdata;
        end
        else if (snap_v_reg && snap_idx_reg == a_idx)
        begin
            opa = snap_data_reg;
        end
        else
        begin
            opa = rfa_q;
        end

        if (!b_ok)
        begin
            opb = 32'd0;
        end
        else if (s2_v_reg && s2_wr_ok_reg && s2_widx_reg == b_idx)
        begin
            opb = s2_wdata;
        end
        else if (snap_v_reg && snap_idx_reg == b_idx)
        begin
            opb = snap_data_reg;
        end
        else
        begin
            opb = rfb_q;
        end
    end

    gie_exec u_exec (
        .func   (s1_func_reg),
        .ins    (s1_ins_reg),
        .pc     (pc_reg),
        .halted (halt_reg),
        .opa    (opa),
        .opb    (opb),
        .res    (ex)
    );

    // Destination range check; writes beyond the register file are dropped.
    assign dest8 = s1_ins_reg[23:16];
    assign wr_ok = ex.wr_en && ({1'b0, dest8} < 9'(REG_COUNT));

    // Load address decode.
    assign ld_seg    = ex.lb_addr[15:12];
    assign ld_widx   = ex.lb_addr[11:2];
    assign ld_seg_ok = (ld_seg == 4'd1) || (ld_seg == 4'd2) || (ld_seg == 4'd3);
    assign ld_idx_ok = ({3'd0, ld_widx} < 13'(SEG_WORDS));
    assign dm_raddr  = seg_base(ld_seg[1:0]) + MA_W'(ld_widx);

    // Store address decode; a store writes as it leaves stage 1.
    assign st_seg   = s1_saddr_reg[15:12];
    assign st_widx  = s1_saddr_reg[11:0];
    assign st_ok    = ((st_seg == 4'd1) || (st_seg == 4'd2) || (st_seg == 4'd3))
                      && ({1'b0, st_widx} < 13'(SEG_WORDS));
    assign dm_we    = clr_busy_reg
                      ? ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(MEM_DEPTH))
                      : (s1_move && s1_func_reg == FUNC_STORE && st_ok);
    assign dm_waddr = clr_busy_reg ? clr_cnt_reg[MA_W-1:0]
                                   : seg_base(st_seg[1:0]) + MA_W'(st_widx);
    assign dm_wdata = clr_busy_reg ? 32'd0 : s1_sword_reg;

    gie_ram #(
        .WIDTH (32),
        .DEPTH (MEM_DEPTH)
    ) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (s2_en),
        .raddr (dm_raddr),
        .rdata (dm_q)
    );

    // Counter values after the item in stage 1.
    assign icnt_next = instr_cnt_reg + (ex.cnt_en ? 32'd1 : 32'd0);
    assign ccnt_next = cyc_cnt_reg + (ex.cnt_en ? 32'(ex.cost) : 32'd0);

    // Architectural state updates as an item leaves stage 1; config loads the pc.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= RESET_PC;
            halt_reg      <= 1'b0;
            instr_cnt_reg <= 32'd0;
            cyc_cnt_reg   <= 32'd0;
        end
        else if (cfg_wr_en)
        begin
            pc_reg <= {16'd0, cfg_wr_data};
        end
        else if (s1_move)
        begin
            pc_reg        <= ex.next_pc;
            halt_reg      <= ex.halt_next;
            instr_cnt_reg <= icnt_next;
            cyc_cnt_reg   <= ccnt_next;
        end
    end

    // Byte select for a load in stage 2.
    always_comb
    begin
        if (!s2_seg_ok_reg)
        begin
            ld_word = OUTSIDE_WORD;
        end
        else if (!s2_idx_ok_reg)
        begin
            ld_word = 32'd0;
        end
        else
        begin
            ld_word = dm_q;
        end
    end

    assign ld_byte  = 8'(ld_word >> {s2_lane_reg, 3'b000});
    assign s2_wdata = s2_is_lb_reg ? {24'd0, ld_byte} : s2_wval_reg;

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg   <= 1'b0;
            snap_v_reg <= 1'b0;
            s2_v_reg   <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_v_reg   <= in_acc;
                snap_v_reg <= pipe_wr;
            end
            if (s2_en)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (out_en)
            begin
                out_v_reg <= s2_v_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_func_reg   <= func;
            s1_ins_reg    <= instruction_word;
            s1_saddr_reg  <= store_address;
            s1_sword_reg  <= store_word;
            snap_idx_reg  <= s2_widx_reg;
            snap_data_reg <= s2_wdata;
        end
        if (s2_en)
        begin
            s2_pc_reg     <= ex.next_pc;
            s2_halt_reg   <= ex.halt_next;
            s2_svc_reg    <= ex.service;
            s2_arg_reg    <= ex.arg;
            s2_icnt_reg   <= icnt_next;
            s2_ccnt_reg   <= ccnt_next;
            s2_wr_ok_reg  <= wr_ok;
            s2_widx_reg   <= dest8[RIDX_W-1:0];
            s2_wval_reg   <= ex.wr_val;
            s2_is_lb_reg  <= ex.is_lb;
            s2_seg_ok_reg <= ld_seg_ok;
            s2_idx_ok_reg <= ld_idx_ok;
            s2_lane_reg   <= ex.lb_addr[1:0];
        end
        if (out_en)
        begin
            out_pc_reg   <= s2_pc_reg;
            out_halt_reg <= s2_halt_reg;
            out_svc_reg  <= s2_svc_reg;
            out_arg_reg  <= s2_arg_reg;
            out_icnt_reg <= s2_icnt_reg;
            out_ccnt_reg <= s2_ccnt_reg;
        end
    end

    // Output ports.
    assign out_valid   = out_v_reg;
    assign next_pc     = out_pc_reg;
    assign halted      = out_halt_reg;
    assign service     = out_svc_reg;
    assign service_arg = out_arg_reg;
    assign instr_count = out_icnt_reg;
    assign cycle_count = out_ccnt_reg;

    // No item is in flight while the memories are being cleared.
    `GPR_ASSERT_ALWAYS(a_clear_empty, clk, clr_busy_reg |-> (!s1_v_reg && !s2_v_reg))
    // Once halted, only reset releases the core.
    `GPR_ASSERT(a_halt_sticky, clk, rst_n, halt_reg |=> halt_reg)
    // Counters move only when an item leaves stage 1.
    `GPR_ASSERT(a_cnt_hold, clk, rst_n, !s1_move |=> ($stable(instr_cnt_reg) && $stable(cyc_cnt_reg)))
    // The pc moves only with an item or a configuration write.
    `GPR_ASSERT(a_pc_hold, clk, rst_n, (!s1_move && !cfg_wr_en) |=> $stable(pc_reg))

endmodule
